// ===== src/ncc_pkg.sv =====
`default_nettype none
package ncc_pkg;

   // Table size; the slot field addresses at most 32 centroids.
   localparam int MAX_CENTROIDS = 32;
   localparam int SLOT_SPACE    = 32;
   localparam int NUM_CELLS     = (MAX_CENTROIDS < SLOT_SPACE) ? MAX_CENTROIDS : SLOT_SPACE;

   localparam int SLOT_W  = 5;
   localparam int CHAN_W  = 8;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int DIST_W  = 9;
   localparam int COUNT_W = 6;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

   // Square root: nine restoring steps, three per pipeline stage.
   localparam int SQRT_STAGES = 3;
   localparam int SQRT_STEPS  = 3;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic [SLOT_W-1:0] slot;
      colour_type        pix;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] distance;
      logic [SLOT_W-1:0] idx;
      colour_type        col;
   } best_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] root;
   } sqrt_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // One pipeline stage worth of the digit-by-digit square root.
   function automatic sqrt_type sqrt_stage(input sqrt_type s, input int stage);
      sqrt_type         r;
      logic [SUM_W-1:0] probe;
      logic [SUM_W-1:0] trial;
      r = s;
      for (int j = 0; j < SQRT_STEPS; j++) begin
         probe = SUM_W'(1) << (SUM_W - 2 - 2 * (stage * SQRT_STEPS + j));
         trial = r.root + probe;
         if (r.rem >= trial) begin
            r.rem  = r.rem - trial;
            r.root = (r.root >> 1) + probe;
         end else begin
            r.root = r.root >> 1;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/ncc_if.sv =====
`default_nettype none
interface ncc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [ncc_pkg::SLOT_W-1:0]  slot;
   logic [ncc_pkg::CHAN_W-1:0]  red;
   logic [ncc_pkg::CHAN_W-1:0]  green;
   logic [ncc_pkg::CHAN_W-1:0]  blue;

   modport source (output valid, cmd, slot, red, green, blue, input ready);
   modport sink   (input valid, cmd, slot, red, green, blue, output ready);
endinterface

interface ncc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ncc_pkg::SLOT_W-1:0]  cluster;
   logic [ncc_pkg::CHAN_W-1:0]  seg_red;
   logic [ncc_pkg::CHAN_W-1:0]  seg_green;
   logic [ncc_pkg::CHAN_W-1:0]  seg_blue;
   logic [ncc_pkg::DIST_W-1:0]  distance;

   modport source (output valid, cluster, seg_red, seg_green, seg_blue, distance,
                   input ready);
   modport sink   (input valid, cluster, seg_red, seg_green, seg_blue, distance,
                   output ready);
endinterface
`default_nettype wire

// ===== src/nearest_colour_centroid_classifier_top.sv =====
`default_nettype none
// Path of an accepted classify transaction to its result: four distance registers and one
// compare register per cell, an item register per cell between cells, then the output register.
// Throughput: one transaction per cycle; the whole cell chain stalls only while a
// result waits in the output register, the sink is not ready and another result
// reaches the end of the chain.
// Reset clears all valid bits and sets the centroid count to 32; the table is not cleared.
module nearest_colour_centroid_classifier_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ncc_req_if.sink                            req_chan,
   ncc_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [ncc_pkg::COUNT_W-1:0]   csr_wdata
);
   import ncc_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] eff_count;
   logic [NUM_CELLS-1:0] active;
   logic adv;

   item_type item_chain [NUM_CELLS+1];
   best_type best_chain [NUM_CELLS+1];

   best_type out_ff;
   best_type out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(NUM_CELLS)) begin
         eff_count = COUNT_W'(NUM_CELLS);
      end else begin
         eff_count = count_ff;
      end
   end

   // The chain moves unless a finished result would overwrite one still waiting.
   assign adv = !(out_ff.valid && !rsp_chan.ready && best_chain[NUM_CELLS].valid);
   assign req_chan.ready = adv;

   always_comb begin
      item_chain[0].valid = req_chan.valid;
      item_chain[0].cmd   = req_chan.cmd;
      item_chain[0].slot  = req_chan.slot;
      item_chain[0].pix   = '{red: req_chan.red, green: req_chan.green, blue: req_chan.blue};
      best_chain[0]       = '{valid: 1'b0, distance: '1, idx: '0, col: '0};
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      assign active[i] = (COUNT_W'(i) < eff_count);

      ncc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_idx (SLOT_W'(i)),
         .active   (active[i]),
         .item_in  (item_chain[i]),
         .item_out (item_chain[i+1]),
         .best_in  (best_chain[i]),
         .best_out (best_chain[i+1])
      );
   end

   always_comb begin
      out_in = out_ff;
      if (adv && best_chain[NUM_CELLS].valid) begin
         out_in = best_chain[NUM_CELLS];
      end else if (rsp_chan.ready) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.distance <= out_in.distance;
      out_ff.idx      <= out_in.idx;
      out_ff.col      <= out_in.col;
   end

   assign rsp_chan.valid     = out_ff.valid;
   assign rsp_chan.cluster   = out_ff.idx;
   assign rsp_chan.seg_red   = out_ff.col.red;
   assign rsp_chan.seg_green = out_ff.col.green;
   assign rsp_chan.seg_blue  = out_ff.col.blue;
   assign rsp_chan.distance  = out_ff.distance;

endmodule
`default_nettype wire

// ===== src/ncc_cell.sv =====
`default_nettype none
module ncc_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic [ncc_pkg::SLOT_W-1:0]  cell_idx,
   input  wire logic                        active,
   input  wire ncc_pkg::item_type           item_in,
   output      ncc_pkg::item_type           item_out,
   input  wire ncc_pkg::best_type           best_in,
   output      ncc_pkg::best_type           best_out
);
   import ncc_pkg::*;

   typedef struct packed {
      logic              valid;
      logic              take;
      logic [SQ_W-1:0]   sq_r;
      logic [SQ_W-1:0]   sq_g;
      logic [SQ_W-1:0]   sq_b;
      colour_type        col;
   } sq_stage_type;

   typedef struct packed {
      logic              valid;
      logic              take;
      sqrt_type          acc;
      colour_type        col;
   } root_stage_type;

   item_type        item_ff;
   colour_type      centroid_ff;
   sq_stage_type    sq_ff;
   sq_stage_type    sq_in;
   root_stage_type  root_ff [SQRT_STAGES];
   root_stage_type  root_in [SQRT_STAGES];
   best_type        best_ff;
   best_type        best_in_nxt;
   sqrt_type        root_last;

   logic [CHAN_W-1:0] dr;
   logic [CHAN_W-1:0] dg;
   logic [CHAN_W-1:0] db;
   logic [DIST_W-1:0] cand_dist;

   assign item_out = item_ff;
   assign best_out = best_ff;

   always_comb begin
      dr = abs_diff(centroid_ff.red,   item_in.pix.red);
      dg = abs_diff(centroid_ff.green, item_in.pix.green);
      db = abs_diff(centroid_ff.blue,  item_in.pix.blue);
      sq_in.valid = item_in.valid && (item_in.cmd == CMD_CLASSIFY);
      sq_in.take  = active;
      sq_in.sq_r  = SQ_W'(dr) * SQ_W'(dr);
      sq_in.sq_g  = SQ_W'(dg) * SQ_W'(dg);
      sq_in.sq_b  = SQ_W'(db) * SQ_W'(db);
      sq_in.col   = centroid_ff;
   end

   // The colour travels with the distance so a later load of this slot
   // cannot change the colour reported for a pixel already in flight.
   always_comb begin
      root_in[0].valid    = sq_ff.valid;
      root_in[0].take     = sq_ff.take;
      root_in[0].col      = sq_ff.col;
      root_in[0].acc.root = '0;
      root_in[0].acc.rem  = {2'b00, sq_ff.sq_r} + {2'b00, sq_ff.sq_g} + {2'b00, sq_ff.sq_b};
      for (int s = 1; s < SQRT_STAGES; s++) begin
         root_in[s]     = root_ff[s-1];
         root_in[s].acc = sqrt_stage(root_ff[s-1].acc, s - 1);
      end
   end

   assign root_last = sqrt_stage(root_ff[SQRT_STAGES-1].acc, SQRT_STAGES - 1);
   assign cand_dist = DIST_W'(root_last.root);

   always_comb begin
      best_in_nxt       = best_in;
      best_in_nxt.valid = root_ff[SQRT_STAGES-1].valid;
      if (root_ff[SQRT_STAGES-1].take && (cand_dist <= best_in.distance)) begin
         best_in_nxt.distance = cand_dist;
         best_in_nxt.idx      = cell_idx;
         best_in_nxt.col      = root_ff[SQRT_STAGES-1].col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
         sq_ff.valid   <= 1'b0;
         best_ff.valid <= 1'b0;
         for (int s = 0; s < SQRT_STAGES; s++) begin
            root_ff[s].valid <= 1'b0;
         end
      end else if (adv) begin
         item_ff.valid <= item_in.valid;
         sq_ff.valid   <= sq_in.valid;
         best_ff.valid <= best_in_nxt.valid;
         for (int s = 0; s < SQRT_STAGES; s++) begin
            root_ff[s].valid <= root_in[s].valid;
         end
      end
      if (adv) begin
         item_ff.cmd      <= item_in.cmd;
         item_ff.slot     <= item_in.slot;
         item_ff.pix      <= item_in.pix;
         sq_ff.take       <= sq_in.take;
         sq_ff.sq_r       <= sq_in.sq_r;
         sq_ff.sq_g       <= sq_in.sq_g;
         sq_ff.sq_b       <= sq_in.sq_b;
         sq_ff.col        <= sq_in.col;
         best_ff.distance <= best_in_nxt.distance;
         best_ff.idx      <= best_in_nxt.idx;
         best_ff.col      <= best_in_nxt.col;
         for (int s = 0; s < SQRT_STAGES; s++) begin
            root_ff[s].take <= root_in[s].take;
            root_ff[s].acc  <= root_in[s].acc;
            root_ff[s].col  <= root_in[s].col;
         end
         if (item_in.valid && (item_in.cmd == CMD_LOAD) && (item_in.slot == cell_idx)) begin
            centroid_ff <= item_in.pix;
         end
      end
   end

endmodule
`default_nettype wire

// ===== tb/ncc_result_checker.sv =====
`timescale 1ns / 100ps
module ncc_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   ncc_req_if                          req_chan,
   ncc_rsp_if                          rsp_chan,
   input  logic                        csr_we,
   input  logic [ncc_pkg::COUNT_W-1:0] csr_wdata,
   output int                          failures,
   output int                          pending
);
   import ncc_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int UNSIGNED_WORST = 255 + 255 + 255;

   typedef struct packed {
      logic [SLOT_W-1:0] cluster;
      colour_type        col;
      logic [DIST_W-1:0] distance;
   } match_type;

   match_type          pending_matches[$];
   colour_type         centroids[NUM_CELLS];
   logic [COUNT_W-1:0] centroid_count;
   int                 reported;

   initial begin
      failures = 0;
      pending  = 0;
      reported = 0;
   end

   function automatic logic [DIST_W-1:0] root_floor(input int unsigned v);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = 511;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo[DIST_W-1:0];
   endfunction

   function automatic int unsigned chan_gap(input logic [CHAN_W-1:0] a,
                                            input logic [CHAN_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // Scans the active slots in order; an equal distance hands the win to the later slot.
   function automatic match_type nearest_centroid(input colour_type pix);
      match_type   best;
      int unsigned n;
      int unsigned best_dist;
      int unsigned dr;
      int unsigned dg;
      int unsigned db;
      int unsigned d;
      n = (centroid_count == 0) ? 1 : centroid_count;
      if (n > NUM_CELLS) begin
         n = NUM_CELLS;
      end
      best      = '0;
      best_dist = UNSIGNED_WORST;
      for (int i = 0; i < n; i++) begin
         dr = chan_gap(centroids[i].red, pix.red);
         dg = chan_gap(centroids[i].green, pix.green);
         db = chan_gap(centroids[i].blue, pix.blue);
         d  = root_floor(dr * dr + dg * dg + db * db);
         if (d <= best_dist) begin
            best_dist    = d;
            best.cluster = i[SLOT_W-1:0];
            best.col     = centroids[i];
         end
      end
      best.distance = best_dist[DIST_W-1:0];
      return best;
   endfunction

   task automatic report_failure(input string what, input match_type want,
                                 input match_type got);
      failures++;
      if (reported < REPORT_LIMIT) begin
         reported++;
         $write("%0t %s: expected cluster %0d colour %h dist %0d, ",
                $time, what, want.cluster, want.col, want.distance);
         $display("got cluster %0d colour %h dist %0d",
                  got.cluster, got.col, got.distance);
      end
   endtask

   always @(posedge clock) begin
      match_type  got;
      match_type  want;
      colour_type pix;
      if (reset) begin
         centroid_count = COUNT_RESET;
         pending_matches.delete();
      end else begin
         if (csr_we) begin
            centroid_count = csr_wdata;
         end
         // Results are retired before new requests so that a transaction is never
         // compared against an expectation queued at the same edge.
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.cluster, rsp_chan.seg_red, rsp_chan.seg_green,
                   rsp_chan.seg_blue, rsp_chan.distance};
            if (pending_matches.size() == 0) begin
               report_failure("unexpected result", '0, got);
            end else begin
               want = pending_matches.pop_front();
               if (got.cluster !== want.cluster || got.col.red !== want.col.red ||
                   got.col.green !== want.col.green || got.col.blue !== want.col.blue ||
                   got.distance !== want.distance) begin
                  report_failure("result mismatch", want, got);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            pix = {req_chan.red, req_chan.green, req_chan.blue};
            if (req_chan.cmd == CMD_LOAD) begin
               if (req_chan.slot < MAX_CENTROIDS) begin
                  centroids[req_chan.slot] = pix;
               end
            end else begin
               pending_matches = {pending_matches, nearest_centroid(pix)};
            end
         end
      end
      pending = pending_matches.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import ncc_pkg::*;

   localparam int LATENCY        = NUM_CELLS + 4;
   localparam int SETTLE         = LATENCY + 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TARGET_ITEMS   = 1650;
   localparam int PHASE_ITEMS    = 140;
   localparam int COUNT_PLAN [0:11] = '{2, 5, 32, 63, 33, 17, 8, 1, 31, 0, 24, 12};

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;
   int                 failures;
   int                 pending;

   ncc_req_if req_chan ();
   ncc_rsp_if rsp_chan ();

   nearest_colour_centroid_classifier_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   ncc_result_checker result_check (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always #5 clock = ~clock;

   colour_type loaded_colour[NUM_CELLS];
   bit         loaded[NUM_CELLS];
   int         items_sent;
   bit         sender_gaps;
   bit         receiver_stalls;
   int         quiet_cycles;

   // Result side: bursts of ready, broken by mostly short and now and then long stalls.
   initial begin
      int run;
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         run = $urandom_range(1, 20);
         repeat (run) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end
         if (receiver_stalls) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
            repeat (stall) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int active_slots(input int value);
      int n;
      n = (value == 0) ? 1 : value;
      return (n > NUM_CELLS) ? NUM_CELLS : n;
   endfunction

   function automatic colour_type random_colour();
      colour_type c;
      c.red   = ($urandom_range(0, 7) == 0) ? {CHAN_W{1'b1}} : CHAN_W'($urandom_range(0, 255));
      c.green = ($urandom_range(0, 7) == 0) ? '0 : CHAN_W'($urandom_range(0, 255));
      c.blue  = CHAN_W'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] v);
      int x;
      x = int'(v) + int'($urandom_range(0, 16)) - 8;
      if (x < 0) begin
         x = 0;
      end else if (x > 255) begin
         x = 255;
      end
      return x[CHAN_W-1:0];
   endfunction

   task automatic idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
   endtask

   task automatic send(input logic cmd, input logic [SLOT_W-1:0] slot, input colour_type c);
      if (sender_gaps) begin
         idle(pick_gap());
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.slot  <= slot;
      req_chan.red   <= c.red;
      req_chan.green <= c.green;
      req_chan.blue  <= c.blue;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      items_sent++;
      if (cmd == CMD_LOAD && slot < NUM_CELLS) begin
         loaded[slot]        = 1'b1;
         loaded_colour[slot] = c;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   // Loads never produce a result, so the pipeline is given its full latency to empty.
   task automatic set_count(input logic [COUNT_W-1:0] value);
      idle(1);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic fill_table(input int n);
      for (int i = 0; i < n; i++) begin
         if (!loaded[i]) begin
            send(CMD_LOAD, SLOT_W'(i), random_colour());
         end
      end
   endtask

   task automatic random_item(input int n);
      int                r;
      int                k;
      logic [SLOT_W-1:0] s;
      colour_type        c;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, n - 1);
      if (r < 30) begin
         s = $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, n - 1))
                                  : SLOT_W'($urandom_range(0, NUM_CELLS - 1));
         // A copy of another slot's colour sets up a tie in later lookups.
         c = ($urandom_range(0, 3) == 0) ? loaded_colour[k] : random_colour();
         send(CMD_LOAD, s, c);
      end else begin
         if (r < 60) begin
            c.red   = nudge(loaded_colour[k].red);
            c.green = nudge(loaded_colour[k].green);
            c.blue  = nudge(loaded_colour[k].blue);
         end else if (r < 85) begin
            c = random_colour();
         end else begin
            c.red   = $urandom_range(0, 1) ? {CHAN_W{1'b1}} : '0;
            c.green = $urandom_range(0, 1) ? {CHAN_W{1'b1}} : '0;
            c.blue  = $urandom_range(0, 1) ? {CHAN_W{1'b1}} : '0;
         end
         send(CMD_CLASSIFY, SLOT_W'($urandom_range(0, 31)), c);
      end
      if ($urandom_range(0, 299) == 0) begin
         idle(1);
         wait_drained();
      end
   endtask

   initial begin
      int value;
      int n;
      int phase;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.cmd    = CMD_LOAD;
      req_chan.slot   = '0;
      req_chan.red    = '0;
      req_chan.green  = '0;
      req_chan.blue   = '0;
      items_sent      = 0;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single centroid: farthest corner of the cube, exact hit, both slot extremes.
      set_count(1);
      send(CMD_LOAD, 5'd0, '{8'd0, 8'd0, 8'd0});
      send(CMD_LOAD, 5'd31, '{8'd255, 8'd255, 8'd255});
      send(CMD_CLASSIFY, 5'd31, '{8'd255, 8'd255, 8'd255});
      send(CMD_CLASSIFY, 5'd0, '{8'd0, 8'd0, 8'd0});
      send(CMD_CLASSIFY, 5'd7, '{8'd255, 8'd0, 8'd255});
      // A count of zero still compares slot 0.
      set_count(0);
      send(CMD_CLASSIFY, 5'd0, '{8'd10, 8'd200, 8'd30});
      // Equal centroids in slots 0 and 1: the later one must win.
      set_count(3);
      send(CMD_LOAD, 5'd1, '{8'd0, 8'd0, 8'd0});
      send(CMD_LOAD, 5'd2, '{8'd255, 8'd255, 8'd255});
      send(CMD_CLASSIFY, 5'd0, '{8'd0, 8'd0, 8'd0});
      send(CMD_CLASSIFY, 5'd0, '{8'd255, 8'd255, 8'd255});
      send(CMD_CLASSIFY, 5'd0, '{8'd128, 8'd128, 8'd128});
      send(CMD_CLASSIFY, 5'd0, '{8'd0, 8'd255, 8'd0});

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         value = (phase < 12) ? COUNT_PLAN[phase] : $urandom_range(0, 63);
         set_count(COUNT_W'(value));
         n               = active_slots(value);
         sender_gaps     = (phase % 4) != 2;
         receiver_stalls = (phase % 4) != 3;
         fill_table(n);
         repeat (PHASE_ITEMS) random_item(n);
         phase++;
      end

      idle(1);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
